FILE: rtl/indirect_shell_sort_core_assert.svh
`ifndef INDIRECT_SHELL_SORT_CORE_ASSERT_SVH
`define INDIRECT_SHELL_SORT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset.
`define ISORT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("isort: implication check failed");
// Next-cycle implication, held off during reset.
`define ISORT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("isort: next-cycle check failed");
`else
`define ISORT_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ISORT_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

FILE: rtl/isort_pkg.sv
package isort_pkg;

    localparam int ENTRIES_DEF   = 128;
    localparam int KEY_WIDTH_DEF = 32;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SORT  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] ACTIVE_COUNT_RST = 8'd128;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr_step;
        logic key_wr;
        logic host_rd;
        logic resp_load;
        logic resp_read;
        logic sort_init;
        logic gap_up;
        logic gap_down;
        logic pos_load;
        logic held_rd;
        logic held_key_rd;
        logic hk_load;
        logic cand_rd;
        logic cand_key_rd;
        logic shift;
        logic place;
    } isort_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;
        logic n_small;
        logic gap_grow;
        logic pos_end;
        logic level_zero;
        logic j_ge_gap;
        logic cand_gt;
    } isort_sts_t;

    // Knuth gap sequence 1, 4, 13, ... by level.
    function automatic logic [11:0] knuth_gap(input logic [2:0] lvl);
        logic [11:0] g;
        unique case (lvl)
            3'd0:    g = 12'd1;
            3'd1:    g = 12'd4;
            3'd2:    g = 12'd13;
            3'd3:    g = 12'd40;
            3'd4:    g = 12'd121;
            3'd5:    g = 12'd364;
            3'd6:    g = 12'd1093;
            default: g = 12'd3280;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/isort_if.sv
interface isort_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic        [6:0]  index;
    logic signed [31:0] key;

    modport source (output valid, cmd, index, key, input ready);
    modport sink   (input valid, cmd, index, key, output ready);
endinterface

interface isort_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] entry_id;
    logic       is_read_data;

    modport source (output valid, entry_id, is_read_data, input ready);
    modport sink   (input valid, entry_id, is_read_data, output ready);
endinterface

interface isort_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] active_count;

    modport source (output valid, active_count, input ready);
    modport sink   (input valid, active_count, output ready);
endinterface

FILE: rtl/indirect_shell_sort_core.sv
// Key write, position read, unused command: one word per cycle unless the response stalls;
//   the result word is registered and shown in the cycle after the word is taken.
// Sort: busy until done, with at most one order-store and one key-store access per step.
// Reset (rst_n low, async) clears control state, then the order store is refilled with the
//   identity; no request word is taken during that pass.
// Configuration writes are taken in every cycle, including during the refill.
module indirect_shell_sort_core #(
    parameter int ENTRIES   = isort_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH = isort_pkg::KEY_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    isort_req_if.sink   req,
    isort_rsp_if.source rsp,
    isort_cfg_if.sink   cfg
);
    import isort_pkg::*;

    // Command and status between the sequencer and the store/datapath.
    isort_cmd_t ctl;
    isort_sts_t sts;

    // The active_count register lives in the datapath; it never stalls the writer.
    assign cfg.ready = 1'b1;

    // Sequencer: request/response handshake, refill pass, shell sort steps.
    isort_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Key store, order store, gap/position counters and the response payload.
    isort_datapath #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .index        (req.index),
        .key          (req.key),
        .cfg_wr       (cfg.valid),
        .cfg_data     (cfg.active_count),
        .entry_id     (rsp.entry_id),
        .is_read_data (rsp.is_read_data)
    );

endmodule

FILE: rtl/isort_datapath.sv
module isort_datapath #(
    parameter int ENTRIES   = isort_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH = isort_pkg::KEY_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  isort_pkg::isort_cmd_t ctl,
    output isort_pkg::isort_sts_t sts,
    input  logic [6:0]          index,
    input  logic signed [31:0]  key,
    input  logic                cfg_wr,
    input  logic [7:0]          cfg_data,
    output logic [6:0]          entry_id,
    output logic                is_read_data
);
    import isort_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [KEY_WIDTH-1:0] key_mem [ENTRIES];
    logic [IDX_W-1:0]     order_mem [ENTRIES];

    logic [7:0]           active_count_reg;
    logic [IDX_W-1:0]     clr_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [2:0]           level_reg;
    logic [CNT_W-1:0]     gap_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [IDX_W-1:0]     held_reg;
    logic [IDX_W-1:0]     cand_reg;
    logic [KEY_WIDTH-1:0] hk_reg;
    logic [IDX_W-1:0]     ord_q_reg;
    logic [KEY_WIDTH-1:0] key_q_reg;
    logic                 out_read_reg;
    logic                 out_hit_reg;

    logic [IDX_W+6:0]     idx_ext;
    logic [IDX_W-1:0]     host_addr;
    logic                 idx_ok;
    logic [63:0]          key_sx;
    logic [CNT_W+7:0]     act_ext;
    logic [CNT_W-1:0]     n_next;
    logic [CNT_W+11:0]    n_ext;
    logic [11:0]          cur_gap;
    logic [11:0]          nxt_gap;
    logic [CNT_W-1:0]     j_back;
    logic                 ord_we;
    logic [IDX_W-1:0]     ord_waddr;
    logic [IDX_W-1:0]     ord_wdata;
    logic                 ord_re;
    logic [IDX_W-1:0]     ord_raddr;
    logic                 key_re;
    logic [IDX_W+6:0]     ord_q_ext;

    assign idx_ext   = {{IDX_W{1'b0}}, index};
    assign host_addr = idx_ext[IDX_W-1:0];
    assign idx_ok    = (idx_ext < (IDX_W + 7)'(ENTRIES));
    assign key_sx    = {{32{key[31]}}, key};

    assign act_ext = {{CNT_W{1'b0}}, active_count_reg};
    assign n_next  = (act_ext > (CNT_W + 8)'(ENTRIES)) ? CNT_W'(ENTRIES)
                                                        : act_ext[CNT_W-1:0];
    assign n_ext   = {12'd0, n_reg};
    assign cur_gap = knuth_gap(level_reg);
    assign nxt_gap = knuth_gap(level_reg + 3'd1);
    assign j_back  = j_reg - gap_reg;

    assign sts.clr_last   = (clr_reg == IDX_W'(ENTRIES - 1));
    assign sts.n_small    = (n_reg < CNT_W'(2));
    assign sts.gap_grow   = (level_reg != 3'd7) && (nxt_gap <= n_ext[11:0]);
    assign sts.pos_end    = (pos_reg >= n_reg);
    assign sts.level_zero = (level_reg == 3'd0);
    assign sts.j_ge_gap   = (j_reg >= gap_reg);
    assign sts.cand_gt    = ($signed(key_q_reg) > $signed(hk_reg));

    // order store port select
    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = clr_reg;
        ord_wdata = clr_reg;
        priority if (ctl.clr_step)
        begin
            ord_we = 1'b1;
        end
        else if (ctl.shift)
        begin
            ord_we    = 1'b1;
            ord_waddr = j_reg[IDX_W-1:0];
            ord_wdata = cand_reg;
        end
        else if (ctl.place)
        begin
            ord_we    = 1'b1;
            ord_waddr = j_reg[IDX_W-1:0];
            ord_wdata = held_reg;
        end
        else
        begin
            ord_we = 1'b0;
        end
    end

    always_comb
    begin
        ord_re    = ctl.host_rd || ctl.held_rd || ctl.cand_rd;
        ord_raddr = host_addr;
        priority if (ctl.held_rd)
        begin
            ord_raddr = pos_reg[IDX_W-1:0];
        end
        else if (ctl.cand_rd)
        begin
            ord_raddr = j_back[IDX_W-1:0];
        end
        else
        begin
            ord_raddr = host_addr;
        end
    end

    assign key_re = ctl.held_key_rd || ctl.cand_key_rd;

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re)
        begin
            ord_q_reg <= order_mem[ord_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.key_wr && idx_ok)
        begin
            key_mem[host_addr] <= key_sx[KEY_WIDTH-1:0];
        end
        if (key_re)
        begin
            key_q_reg <= key_mem[ord_q_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.held_key_rd)
        begin
            held_reg <= ord_q_reg;
        end
        if (ctl.cand_key_rd)
        begin
            cand_reg <= ord_q_reg;
        end
        if (ctl.hk_load)
        begin
            hk_reg <= key_q_reg;
        end
        if (ctl.resp_load)
        begin
            out_read_reg <= ctl.resp_read;
            out_hit_reg  <= ctl.resp_read && idx_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= ACTIVE_COUNT_RST;
            clr_reg          <= '0;
            n_reg            <= '0;
            level_reg        <= '0;
            gap_reg          <= '0;
            pos_reg          <= '0;
            j_reg            <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                active_count_reg <= cfg_data;
            end
            if (ctl.clr_step)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (ctl.sort_init)
            begin
                n_reg     <= n_next;
                level_reg <= '0;
            end
            if (ctl.gap_up)
            begin
                level_reg <= level_reg + 3'd1;
            end
            if (ctl.gap_down)
            begin
                level_reg <= level_reg - 3'd1;
            end
            if (ctl.pos_load)
            begin
                gap_reg <= cur_gap[CNT_W-1:0];
                pos_reg <= cur_gap[CNT_W-1:0];
            end
            if (ctl.held_key_rd)
            begin
                j_reg <= pos_reg;
            end
            if (ctl.shift)
            begin
                j_reg <= j_back;
            end
            if (ctl.place)
            begin
                pos_reg <= pos_reg + CNT_W'(1);
            end
        end
    end

    assign ord_q_ext    = {7'd0, ord_q_reg};
    assign entry_id     = out_hit_reg ? ord_q_ext[6:0] : 7'd0;
    assign is_read_data = out_read_reg;

endmodule

FILE: rtl/isort_ctrl.sv
`include "indirect_shell_sort_core_assert.svh"

module isort_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic [1:0]            req_cmd,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  isort_pkg::isort_sts_t sts,
    output isort_pkg::isort_cmd_t ctl
);
    import isort_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b000000000001,
        S_IDLE     = 12'b000000000010,
        S_SETUP    = 12'b000000000100,
        S_GAP      = 12'b000000001000,
        S_POS_INIT = 12'b000000010000,
        S_POS_CHK  = 12'b000000100000,
        S_HELD_K   = 12'b000001000000,
        S_HELD_W   = 12'b000010000000,
        S_J_CHK    = 12'b000100000000,
        S_CAND_K   = 12'b001000000000,
        S_CAND_CMP = 12'b010000000000,
        S_DONE     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   sorting;

    assign req_ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign sorting   = (state_reg != S_IDLE) && (state_reg != S_CLEAR)
                       && (state_reg != S_DONE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        ctl            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_cmd == CMD_SORT)
                    begin
                        ctl.sort_init = 1'b1;
                        state_next    = S_SETUP;
                    end
                    else
                    begin
                        ctl.key_wr     = (req_cmd == CMD_WRITE);
                        ctl.host_rd    = (req_cmd == CMD_READ);
                        ctl.resp_load  = 1'b1;
                        ctl.resp_read  = (req_cmd == CMD_READ);
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_SETUP:
            begin
                state_next = sts.n_small ? S_DONE : S_GAP;
            end
            S_GAP:
            begin
                if (sts.gap_grow)
                begin
                    ctl.gap_up = 1'b1;
                end
                else
                begin
                    state_next = S_POS_INIT;
                end
            end
            S_POS_INIT:
            begin
                ctl.pos_load = 1'b1;
                state_next   = S_POS_CHK;
            end
            S_POS_CHK:
            begin
                if (sts.pos_end)
                begin
                    if (sts.level_zero)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.gap_down = 1'b1;
                        state_next   = S_POS_INIT;
                    end
                end
                else
                begin
                    ctl.held_rd = 1'b1;
                    state_next  = S_HELD_K;
                end
            end
            S_HELD_K:
            begin
                ctl.held_key_rd = 1'b1;
                state_next      = S_HELD_W;
            end
            S_HELD_W:
            begin
                ctl.hk_load = 1'b1;
                state_next  = S_J_CHK;
            end
            S_J_CHK:
            begin
                if (sts.j_ge_gap)
                begin
                    ctl.cand_rd = 1'b1;
                    state_next  = S_CAND_K;
                end
                else
                begin
                    ctl.place  = 1'b1;
                    state_next = S_POS_CHK;
                end
            end
            S_CAND_K:
            begin
                ctl.cand_key_rd = 1'b1;
                state_next      = S_CAND_CMP;
            end
            S_CAND_CMP:
            begin
                if (sts.cand_gt)
                begin
                    ctl.shift  = 1'b1;
                    state_next = S_J_CHK;
                end
                else
                begin
                    ctl.place  = 1'b1;
                    state_next = S_POS_CHK;
                end
            end
            S_DONE:
            begin
                ctl.resp_load  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ISORT_ASSERT_NXT(a_sort_goes_busy, clk, rst_n, accept && (req_cmd == CMD_SORT), !req_ready)
    `ISORT_ASSERT_IMP(a_no_word_while_sorting, clk, rst_n, sorting, !out_valid_reg)
    `ISORT_ASSERT_NXT(a_done_gives_word, clk, rst_n, state_reg == S_DONE, out_valid_reg)
    `ISORT_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, state_reg == S_CLEAR, !req_ready)

endmodule

FILE: dv/indirect_shell_sort_core_tb.sv
`timescale 1ns / 1ps

module indirect_shell_sort_core_tb;
    import isort_pkg::*;

    localparam int SLOTS        = ENTRIES_DEF;
    localparam int GAP_MULT     = 3;       // Knuth gaps: g = 3g + 1
    localparam int HOLD_CYCLES  = 400;     // long response hold-off
    localparam int LIMIT_CYCLES = 3000000;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [1:0] CMD_NONE = 2'd3; // unused command, answered and ignored

    typedef struct packed {
        logic [1:0]         cmd;
        logic [6:0]         index;
        logic signed [31:0] key;
    } req_word_t;

    typedef struct packed {
        logic [6:0] entry_id;
        logic       is_read_data;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n;

    isort_req_if req_bus ();
    isort_rsp_if rsp_bus ();
    isort_cfg_if cfg_bus ();

    indirect_shell_sort_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    always #5 clk = ~clk;

    // Local copy of the engine state.
    logic signed [31:0] key_mem   [SLOTS];
    logic [6:0]         order_mem [SLOTS];
    logic [7:0]         count_reg;

    req_word_t cmd_q    [$];   // words waiting to be offered
    rsp_word_t answer_q [$];   // answers owed by the block, oldest first

    int  words_queued = 0;
    int  words_sent   = 0;
    int  fail_count   = 0;
    int  cycle_count  = 0;
    int  idle_pct     = 0;     // chance of starting an idle burst, both sides
    int  src_gap      = 0;
    int  snk_gap      = 0;
    logic req_fire    = 1'b0;  // request handshake seen at the last rising edge
    logic rsp_hold    = 1'b0;

    event hold_off_go;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Shell sort of the first count_reg order positions by key, strictly
    // greater moves an entry back; equal keys stay where the passes put them.
    function automatic void shell_sort_order();
        int n;
        int gap;
        int pos;
        int j;
        logic [6:0]         held;
        logic signed [31:0] held_key;
        n = count_reg;
        if (n > SLOTS)
            n = SLOTS;
        if (n < 2)
            return;
        gap = 1;
        while (gap <= n)
            gap = gap * GAP_MULT + 1;
        do
        begin
            gap = gap / GAP_MULT;
            for (pos = gap; pos < n; pos++)
            begin
                held     = order_mem[pos];
                held_key = key_mem[held];
                j        = pos;
                while (j >= gap && key_mem[order_mem[j - gap]] > held_key)
                begin
                    order_mem[j] = order_mem[j - gap];
                    j = j - gap;
                end
                order_mem[j] = held;
            end
        end
        while (gap > 1);
    endfunction

    // Applies one request word to the local state, returns the response word.
    function automatic rsp_word_t answer_for(input req_word_t w);
        rsp_word_t r;
        r = '0;
        case (w.cmd)
            CMD_WRITE: key_mem[w.index] = w.key;
            CMD_SORT:  shell_sort_order();
            CMD_READ:
            begin
                r.is_read_data = 1'b1;
                r.entry_id     = order_mem[w.index];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Handshake sampling and prediction at the rising edge.
    always @(posedge clk)
    begin : req_take
        req_word_t w;
        req_fire <= rst_n && req_bus.valid && req_bus.ready;
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            w.cmd   = req_bus.cmd;
            w.index = req_bus.index;
            w.key   = req_bus.key;
            words_sent++;
            answer_q.push_back(answer_for(w));
        end
    end

    // New word, hold or idle burst at the falling edge. A word on the bus
    // stays until the edge that takes it.
    always @(negedge clk)
    begin : req_drive
        req_word_t w;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else if (!req_bus.valid || req_fire)
        begin
            if (src_gap > 0)
            begin
                src_gap = src_gap - 1;
                req_bus.valid <= 1'b0;
            end
            else if (cmd_q.size() != 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                src_gap = $urandom_range(0, 3);
                req_bus.valid <= 1'b0;
            end
            else if (cmd_q.size() != 0)
            begin
                w = cmd_q.pop_front();
                req_bus.valid <= 1'b1;
                req_bus.cmd   <= w.cmd;
                req_bus.index <= w.index;
                req_bus.key   <= w.key;
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : rsp_check
        rsp_word_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (answer_q.size() == 0)
            begin
                $error("unexpected word: entry_id %0d is_read_data %0d",
                       rsp_bus.entry_id, rsp_bus.is_read_data);
                fail_count++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (rsp_bus.entry_id !== want.entry_id)
                begin
                    $error("entry_id: expected %0d, actual %0d",
                           want.entry_id, rsp_bus.entry_id);
                    fail_count++;
                end
                if (rsp_bus.is_read_data !== want.is_read_data)
                begin
                    $error("is_read_data: expected %0d, actual %0d",
                           want.is_read_data, rsp_bus.is_read_data);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin : rsp_drive
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else if (rsp_hold)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap = snk_gap - 1;
            rsp_bus.ready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            snk_gap = $urandom_range(0, 3);
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // Long hold-off of the response side; the block backs up into the
    // request side while the driver keeps offering words.
    always
    begin : hold_off
        @(hold_off_go);
        @(posedge clk);
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_word(input logic [1:0] c, input logic [6:0] i, input logic [31:0] k);
        req_word_t w;
        w.cmd   = c;
        w.index = i;
        w.key   = k;
        cmd_q.push_back(w);
        words_queued++;
    endtask

    // Returns at a falling edge once every queued word was taken and answered.
    task automatic drain();
        do
            @(negedge clk);
        while (words_sent != words_queued || answer_q.size() != 0);
    endtask

    // Count register write; only called with the block idle, at a falling edge.
    task automatic set_count(input logic [7:0] n);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.active_count <= n;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        count_reg = n;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Small keys give plenty of ties; the rest are extremes or full range.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_key = 32'($signed($urandom_range(0, 4)) - 2);
            4:          pick_key = 32'h7FFF_FFFF;
            5:          pick_key = 32'h8000_0000;
            default:    pick_key = $urandom;
        endcase
    endfunction

    // Counts at the sort boundaries: no-op, minimum, gap edges, full, saturating.
    function automatic logic [7:0] corner_count(input int k);
        case (k)
            0:  corner_count = 8'd0;
            1:  corner_count = 8'd1;
            2:  corner_count = 8'd2;
            3:  corner_count = 8'd3;
            4:  corner_count = 8'd4;
            5:  corner_count = 8'd5;
            6:  corner_count = 8'd13;
            7:  corner_count = 8'd14;
            8:  corner_count = 8'd40;
            9:  corner_count = 8'd41;
            10: corner_count = 8'd121;
            11: corner_count = 8'd122;
            12: corner_count = 8'd127;
            13: corner_count = 8'd128;
            14: corner_count = 8'd129;
            default: corner_count = 8'd255;
        endcase
    endfunction

    // One phase: a few write / sort / read-back sequences with random noise.
    task automatic run_phase(input logic [7:0] n);
        int eff;
        int p;
        eff = (n > SLOTS) ? SLOTS : n;
        repeat ($urandom_range(1, 3))
        begin
            repeat ($urandom_range(1, 12))
                push_word(CMD_WRITE, 7'($urandom_range(0, SLOTS - 1)), pick_key());
            push_word(CMD_SORT, 7'($urandom), $urandom);
            if (eff <= 24)
            begin
                for (p = 0; p < eff || p < 2; p++)
                    push_word(CMD_READ, 7'(p), $urandom);
            end
            else
            begin
                repeat (24)
                    push_word(CMD_READ, 7'($urandom_range(0, eff - 1)), $urandom);
            end
            // noise: any command, any index, any key
            repeat ($urandom_range(0, 4))
                push_word(2'($urandom_range(0, 3)), 7'($urandom), $urandom);
        end
    endtask

    initial
    begin : main_seq
        int i;
        int phase;
        logic [7:0] n;

        for (i = 0; i < SLOTS; i++)
        begin
            key_mem[i]   = '0;
            order_mem[i] = 7'(i);
        end
        count_reg = ACTIVE_COUNT_RST;

        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.cmd          = CMD_WRITE;
        req_bus.index        = '0;
        req_bus.key          = '0;
        rsp_bus.ready        = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.active_count = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: identity order out of reset, unused command with all bits set.
        idle_pct = 10;
        push_word(CMD_READ, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd127, 32'd0);
        push_word(CMD_NONE, 7'd127, 32'hFFFF_FFFF);

        // Fill every key so no sort ever looks at an unwritten entry;
        // largest, smallest, zero and minus one among them.
        for (i = 0; i < SLOTS; i++)
        begin
            case (i)
                5:       push_word(CMD_WRITE, 7'(i), 32'h7FFF_FFFF);
                6:       push_word(CMD_WRITE, 7'(i), 32'h8000_0000);
                7:       push_word(CMD_WRITE, 7'(i), 32'h0000_0000);
                8:       push_word(CMD_WRITE, 7'(i), 32'hFFFF_FFFF);
                default: push_word(CMD_WRITE, 7'(i), pick_key());
            endcase
        end

        // Full sort at the reset count.
        push_word(CMD_SORT, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd1, 32'd0);
        push_word(CMD_READ, 7'd64, 32'd0);
        push_word(CMD_READ, 7'd127, 32'd0);

        // Count zero and one leave the order alone.
        drain();
        set_count(8'd0);
        push_word(CMD_SORT, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd1, 32'd0);
        drain();
        set_count(8'd1);
        push_word(CMD_SORT, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd0, 32'd0);

        // Count above the entry number saturates.
        drain();
        set_count(8'd255);
        push_word(CMD_WRITE, 7'd5, 32'h8000_0000);
        push_word(CMD_SORT, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd127, 32'd0);

        drain();
        set_count(8'd2);
        push_word(CMD_SORT, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd0, 32'd0);
        push_word(CMD_READ, 7'd1, 32'd0);

        // Random phases; the block is drained before every count change.
        phase = 0;
        while (words_queued < 1650)
        begin
            drain();
            if (phase < 16)
                n = corner_count(phase);
            else if ($urandom_range(0, 99) < 75)
                n = 8'($urandom_range(0, 24));
            else if ($urandom_range(0, 1) == 0)
                n = 8'($urandom_range(25, 127));
            else
                n = 8'($urandom_range(128, 255));
            set_count(n);

            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 10 * $urandom_range(1, 3);

            if (phase == 2)
            begin
                // Response side stalls for a long stretch while requests
                // keep coming, so the block fills and backs up.
                idle_pct = 0;
                -> hold_off_go;
                repeat (80)
                    push_word(($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE,
                              7'($urandom), pick_key());
            end
            else
            begin
                run_phase(n);
            end
            phase++;
        end

        // Last stretch without idling on either side.
        while (words_queued < 1850)
        begin
            drain();
            idle_pct = 0;
            n = 8'($urandom_range(0, 24));
            set_count(n);
            run_phase(n);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && answer_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
